>>> rtl/core/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// types and constants shared by the cache simulator modules
// ----------------------------------------------------------------------------
package salc_pkg;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_RESPOND,
      ST_CLEAR
   } state_type;

   localparam logic [1:0] REG_SET_BITS   = 2'd0;
   localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS       = 2'd2;

   localparam logic [2:0] SET_BITS_RESET   = 3'd4;
   localparam logic [5:0] BLOCK_BITS_RESET = 6'd4;
   localparam logic [3:0] WAYS_RESET       = 4'd1;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic rd_set;
      logic update;
      logic second;
      logic resp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } status_type;

endpackage

>>> rtl/core/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl
// sequencer: clearing pass, set read, update per access, result hand-off
// ----------------------------------------------------------------------------
module salc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  salc_pkg::op_type     req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output salc_pkg::cmd_type    cmd,
   input  salc_pkg::status_type status
);

   salc_pkg::state_type state_ff, state_in;
   logic                second_ff, second_in;
   logic                modify_ff, modify_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_CLEAR;
         second_ff    <= 1'b0;
         modify_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         modify_ff    <= modify_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      second_in    = second_ff;
      modify_in    = modify_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         salc_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end
         salc_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               second_in   = 1'b0;
               modify_in   = (req_op == salc_pkg::OP_MODIFY);
               if (req_op == salc_pkg::OP_NONE) begin
                  state_in = salc_pkg::ST_RESPOND;
               end else begin
                  state_in = salc_pkg::ST_READ;
               end
            end
         end
         salc_pkg::ST_READ: begin
            cmd.rd_set = 1'b1;
            state_in   = salc_pkg::ST_UPDATE;
         end
         salc_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            cmd.second = second_ff;
            if (modify_ff && !second_ff) begin
               second_in = 1'b1;
               state_in  = salc_pkg::ST_READ;
            end else begin
               state_in = salc_pkg::ST_RESPOND;
            end
         end
         salc_pkg::ST_RESPOND: begin
            cmd.resp_load = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = salc_pkg::ST_IDLE;
         end
         default: begin
            state_in = salc_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != salc_pkg::ST_IDLE) |-> !req_ready)
      else $error("item accepted while busy");
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |=> rsp_valid)
      else $error("result not raised");
   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_set |=> cmd.update)
      else $error("read not followed by update");
`endif

endmodule

>>> rtl/core/salc_dpath.sv
// ----------------------------------------------------------------------------
// salc_dpath
// set memory, tag compare, lru ranks, totals and result register
// ----------------------------------------------------------------------------
module salc_dpath #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  salc_pkg::cmd_type       cmd,
   output salc_pkg::status_type    status,
   input  logic [2:0]              set_bits,
   input  logic [5:0]              block_bits,
   input  logic [3:0]              ways_in_use,
   input  logic [ADDR_WIDTH-1:0]   req_address,
   output logic                    rsp_first_hit,
   output logic                    rsp_first_miss,
   output logic                    rsp_evicted,
   output logic                    rsp_second_hit,
   output logic [31:0]             rsp_hit_total,
   output logic [31:0]             rsp_miss_total,
   output logic [31:0]             rsp_eviction_total
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W   = WAY_W;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   typedef struct packed {
      logic                  valid;
      logic [RANK_W-1:0]     rank;
      logic [ADDR_WIDTH-1:0] tag;
   } line_type;

   line_type              mem_ff [NUM_SETS][MAX_WAYS];
   line_type              rd_ff [MAX_WAYS];
   logic [MAX_SET_BITS-1:0] clr_ff;
   logic                  clr_done_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [MAX_SET_BITS-1:0] set_ff;
   logic [ADDR_WIDTH-1:0] tag_ff;
   logic                  fh_ff, fm_ff, ev_ff, sh_ff;
   logic [31:0]           hits_ff, misses_ff, evs_ff;
   logic                  o_fh_ff, o_fm_ff, o_ev_ff, o_sh_ff;
   logic [31:0]           o_hits_ff, o_misses_ff, o_evs_ff;

   // address split, from captured address
   logic [5:0]            s_eff;
   logic [6:0]            sb_sum;
   logic [ADDR_WIDTH-1:0] sh_addr, set_mask;
   logic [MAX_SET_BITS-1:0] set_calc;
   logic [ADDR_WIDTH-1:0] tag_calc;
   logic [3:0]            ways_eff;

   always_comb begin
      s_eff = (32'(set_bits) > MAX_SET_BITS) ? 6'(MAX_SET_BITS) : {3'b0, set_bits};
      sb_sum = {1'b0, s_eff} + {1'b0, block_bits};
      sh_addr = addr_ff >> block_bits;
      set_mask = ~({ADDR_WIDTH{1'b1}} << s_eff);
      set_calc = MAX_SET_BITS'(sh_addr & set_mask);
      tag_calc = (sb_sum >= 7'd64) ? '0 : (addr_ff >> sb_sum);
      if (ways_in_use == 4'd0) begin
         ways_eff = 4'd1;
      end else if (32'(ways_in_use) > MAX_WAYS) begin
         ways_eff = 4'(MAX_WAYS);
      end else begin
         ways_eff = ways_in_use;
      end
   end

   // lookup on the registered set
   logic                  hit;
   logic [WAY_W-1:0]      hit_way, empty_way, victim_way, use_way;
   logic                  full;
   logic [RANK_W-1:0]     best, old_rank;
   line_type              wr [MAX_WAYS];

   always_comb begin
      hit = 1'b0; hit_way = '0; empty_way = '0; full = 1'b1;
      best = '0; victim_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (w < ways_eff) begin
            if (rd_ff[w].valid && rd_ff[w].tag == tag_ff) begin
               hit = 1'b1; hit_way = WAY_W'(w);
            end
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < ways_eff) begin
            if (!rd_ff[w].valid) begin
               empty_way = WAY_W'(w); full = 1'b0;
            end
            if (rd_ff[w].rank > best) begin
               best = rd_ff[w].rank; victim_way = WAY_W'(w);
            end
         end
      end
      use_way  = hit ? hit_way : (full ? victim_way : empty_way);
      old_rank = hit ? rd_ff[hit_way].rank : RANK_MAX;
      for (int w = 0; w < MAX_WAYS; w++) begin
         wr[w] = rd_ff[w];
         if (w < ways_eff && WAY_W'(w) != use_way && rd_ff[w].valid &&
             (hit ? (rd_ff[w].rank < old_rank) : 1'b1) && rd_ff[w].rank < RANK_MAX) begin
            wr[w].rank = rd_ff[w].rank + 1'b1;
         end
      end
      wr[use_way].rank  = '0;
      wr[use_way].valid = 1'b1;
      wr[use_way].tag   = tag_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            mem_ff[clr_ff][w].valid <= 1'b0;
            mem_ff[clr_ff][w].rank  <= '0;
         end
      end else if (cmd.update) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            mem_ff[set_ff][w] <= wr[w];
         end
      end
      if (cmd.rd_set) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            rd_ff[w] <= mem_ff[set_calc][w];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         hits_ff     <= '0;
         misses_ff   <= '0;
         evs_ff      <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff      <= clr_ff + 1'b1;
            clr_done_ff <= (clr_ff == MAX_SET_BITS'(NUM_SETS - 2)) ||
                           (NUM_SETS == 2 && clr_ff != '0);
         end
         if (cmd.update) begin
            if (hit) begin
               if (hits_ff != '1) hits_ff <= hits_ff + 1'b1;
            end else begin
               if (misses_ff != '1) misses_ff <= misses_ff + 1'b1;
               if (full && evs_ff != '1) evs_ff <= evs_ff + 1'b1;
            end
         end
      end
   end

   assign status.clear_done = clr_done_ff && (clr_ff == '1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff <= req_address;
         fh_ff <= 1'b0; fm_ff <= 1'b0; ev_ff <= 1'b0; sh_ff <= 1'b0;
      end
      if (cmd.rd_set) begin
         set_ff <= set_calc;
         tag_ff <= tag_calc;
      end
      if (cmd.update) begin
         if (cmd.second) begin
            sh_ff <= hit;
         end else begin
            fh_ff <= hit; fm_ff <= !hit;
         end
         if (!hit && full) ev_ff <= 1'b1;
      end
      if (cmd.resp_load) begin
         o_fh_ff <= fh_ff; o_fm_ff <= fm_ff; o_ev_ff <= ev_ff; o_sh_ff <= sh_ff;
         o_hits_ff <= hits_ff; o_misses_ff <= misses_ff; o_evs_ff <= evs_ff;
      end
   end

   assign rsp_first_hit      = o_fh_ff;
   assign rsp_first_miss     = o_fm_ff;
   assign rsp_evicted        = o_ev_ff;
   assign rsp_second_hit     = o_sh_ff;
   assign rsp_hit_total      = o_hits_ff;
   assign rsp_miss_total     = o_misses_ff;
   assign rsp_eviction_total = o_evs_ff;

`ifndef SYNTHESIS
   a_hit_excl_miss: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> !(fh_ff && fm_ff))
      else $error("hit and miss together");
   a_second_hits: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && cmd.second) |-> hit)
      else $error("second access of modify missed");
   a_hits_mono: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(hits_ff))
      else $error("hit total moved without access");
`endif

endmodule

>>> rtl/core/set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// set-associative cache hit/miss simulator with lru replacement
// ----------------------------------------------------------------------------
// Each item is one access; a load or store reads the set, updates the set
// and loads the result, a modify reads and updates the set twice before
// loading the result, and an unused op only loads the result. The block
// works through one access at a time: the next item is taken only once the
// result is loaded and the receiver has taken any earlier result.
// After reset a clearing pass over all 2**MAX_SET_BITS sets runs before
// the first item is taken. Registers: 0 set_bits, 1 block_bits, 2 ways_in_use.
module set_assoc_lru_cache_sim #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [ADDR_WIDTH-1:0] req_address,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_first_hit,
   output logic                  rsp_first_miss,
   output logic                  rsp_evicted,
   output logic                  rsp_second_hit,
   output logic [31:0]           rsp_hit_total,
   output logic [31:0]           rsp_miss_total,
   output logic [31:0]           rsp_eviction_total,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   salc_pkg::cmd_type    cmd;
   salc_pkg::status_type status;
   logic [2:0]           set_bits_ff;
   logic [5:0]           block_bits_ff;
   logic [3:0]           ways_ff;
   logic [1:0]           reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= salc_pkg::SET_BITS_RESET;
         block_bits_ff <= salc_pkg::BLOCK_BITS_RESET;
         ways_ff       <= salc_pkg::WAYS_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_idx)
            salc_pkg::REG_SET_BITS:   set_bits_ff   <= pwdata[2:0];
            salc_pkg::REG_BLOCK_BITS: block_bits_ff <= pwdata[5:0];
            salc_pkg::REG_WAYS:       ways_ff       <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         salc_pkg::REG_SET_BITS:   prdata = {29'b0, set_bits_ff};
         salc_pkg::REG_BLOCK_BITS: prdata = {26'b0, block_bits_ff};
         salc_pkg::REG_WAYS:       prdata = {28'b0, ways_ff};
         default:                  prdata = '0;
      endcase
   end

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (salc_pkg::op_type'(req_op)),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   salc_dpath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .set_bits           (set_bits_ff),
      .block_bits         (block_bits_ff),
      .ways_in_use        (ways_ff),
      .req_address        (req_address),
      .rsp_first_hit      (rsp_first_hit),
      .rsp_first_miss     (rsp_first_miss),
      .rsp_evicted        (rsp_evicted),
      .rsp_second_hit     (rsp_second_hit),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

endmodule

>>> tb/tb_set_assoc_lru_cache_sim.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim
// self-checking bench for the lru cache hit/miss simulator
// ----------------------------------------------------------------------------
// A behavioural cache model predicts the flags and totals of every access.
// Directed accesses cover the register extremes and the odd cases, then
// random access streams run under several geometries with random gaps on
// both sides, a long receiver hold-off and a full drain before each
// register write.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_sim;

   localparam int MSB    = 6;
   localparam int MWAYS  = 8;
   localparam int NSETS  = 1 << MSB;
   localparam int WDOG   = 20000;

   typedef struct {
      logic        fh;
      logic        fm;
      logic        ev;
      logic        sh;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evicts;
   } access_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = 2'd0;
   logic [63:0] req_address = 64'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_first_hit, rsp_first_miss, rsp_evicted, rsp_second_hit;
   logic [31:0] rsp_hit_total, rsp_miss_total, rsp_eviction_total;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   set_assoc_lru_cache_sim dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [2:0]  cfg_sets = salc_pkg::SET_BITS_RESET;
   logic [5:0]  cfg_block = salc_pkg::BLOCK_BITS_RESET;
   logic [3:0]  cfg_ways = salc_pkg::WAYS_RESET;
   logic        mdl_valid [NSETS][MWAYS];
   logic [63:0] mdl_tag [NSETS][MWAYS];
   logic [2:0]  mdl_rank [NSETS][MWAYS];
   logic [31:0] mdl_hits = 0, mdl_misses = 0, mdl_evicts = 0;

   access_result_type pending_results[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  hold_rsp = 1'b0;
   int  hold_len = 0;

   initial begin
      foreach (mdl_valid[s, w]) begin
         mdl_valid[s][w] = 1'b0;
         mdl_rank[s][w]  = 3'd0;
         mdl_tag[s][w]   = 64'd0;
      end
   end

   function automatic logic [31:0] sat_add(logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 32'd1;
   endfunction

   function automatic void promote(int s, int ways, int used, int old_rank);
      for (int w = 0; w < ways; w++)
         if (w != used && mdl_valid[s][w] && mdl_rank[s][w] < old_rank &&
             mdl_rank[s][w] < MWAYS - 1)
            mdl_rank[s][w]++;
      mdl_rank[s][used] = 3'd0;
   endfunction

   function automatic bit cache_lookup(logic [63:0] addr, output bit ev);
      int s, b, ways, set_idx, empty, victim, best;
      logic [63:0] tag;
      bit full;
      s = (cfg_sets > MSB) ? MSB : int'(cfg_sets);
      b = int'(cfg_block);
      ways = (cfg_ways == 0) ? 1 : (cfg_ways > MWAYS) ? MWAYS : int'(cfg_ways);
      set_idx = (b >= 64) ? 0 : int'((addr >> b) & ((64'd1 << s) - 64'd1));
      tag = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
      ev = 1'b0;
      empty = 0;
      victim = 0;
      best = 0;
      full = 1'b1;
      for (int w = 0; w < ways; w++) begin
         if (mdl_valid[set_idx][w]) begin
            if (mdl_tag[set_idx][w] == tag) begin
               mdl_hits = sat_add(mdl_hits);
               promote(set_idx, ways, w, int'(mdl_rank[set_idx][w]));
               return 1'b1;
            end
         end else begin
            empty = w;
            full = 1'b0;
         end
      end
      mdl_misses = sat_add(mdl_misses);
      if (!full) begin
         mdl_valid[set_idx][empty] = 1'b1;
         mdl_tag[set_idx][empty] = tag;
         promote(set_idx, ways, empty, MWAYS);
      end else begin
         mdl_evicts = sat_add(mdl_evicts);
         ev = 1'b1;
         for (int w = 0; w < ways; w++)
            if (mdl_rank[set_idx][w] > best) begin
               best = int'(mdl_rank[set_idx][w]);
               victim = w;
            end
         mdl_tag[set_idx][victim] = tag;
         promote(set_idx, ways, victim, MWAYS);
      end
      return 1'b0;
   endfunction

   function automatic access_result_type predict_access(logic [1:0] op, logic [63:0] addr);
      access_result_type r;
      bit ev, h;
      r = '{default: 1'b0, hits: 0, misses: 0, evicts: 0};
      if (op != salc_pkg::OP_NONE) begin
         h = cache_lookup(addr, ev);
         r.fh = h;
         r.fm = !h;
         r.ev = ev;
         if (op == salc_pkg::OP_MODIFY) begin
            r.sh = cache_lookup(addr, ev);
            if (ev) r.ev = 1'b1;
         end
      end
      r.hits = mdl_hits;
      r.misses = mdl_misses;
      r.evicts = mdl_evicts;
      return r;
   endfunction

   task automatic send_access(logic [1:0] op, logic [63:0] addr);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_access(op, addr));
      @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         salc_pkg::REG_SET_BITS:   cfg_sets = value[2:0];
         salc_pkg::REG_BLOCK_BITS: cfg_block = value[5:0];
         salc_pkg::REG_WAYS:       cfg_ways = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic setup_cache(int sb, int bb, int wy);
      drain();
      write_reg(salc_pkg::REG_SET_BITS, sb);
      write_reg(salc_pkg::REG_BLOCK_BITS, bb);
      write_reg(salc_pkg::REG_WAYS, wy);
   endtask

   function automatic logic [63:0] rand_addr64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [1:0] rand_op();
      return (($urandom_range(0, 19) == 0) ? salc_pkg::OP_NONE :
              salc_pkg::op_type'($urandom_range(0, 2)));
   endfunction

   // addresses from a small pool of lines so that hits and evictions happen
   task automatic random_stream(int n, int pool);
      logic [63:0] lines [];
      logic [63:0] a;
      lines = new[pool];
      foreach (lines[i]) lines[i] = rand_addr64();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) a = rand_addr64();
         else a = lines[$urandom_range(0, pool - 1)] ^ {32'd0, 28'd0, 4'($urandom())};
         send_access(rand_op(), a);
      end
   endtask

   task automatic test_directed;
      send_access(salc_pkg::OP_LOAD, 64'd0);
      send_access(salc_pkg::OP_LOAD, 64'd0);
      send_access(salc_pkg::OP_STORE, 64'hffff_ffff_ffff_ffff);
      send_access(salc_pkg::OP_MODIFY, 64'h1234_5678_9abc_def0);
      send_access(salc_pkg::OP_NONE, 64'haaaa_5555_aaaa_5555);
      send_access(salc_pkg::OP_MODIFY, 64'h5555_aaaa_5555_aaaa);
      setup_cache(7, 32, 0);
      send_access(salc_pkg::OP_LOAD, 64'hffff_ffff_0000_0000);
      send_access(salc_pkg::OP_LOAD, 64'h0000_0000_ffff_ffff);
      setup_cache(6, 60, 15);
      for (int i = 0; i < 10; i++) send_access(salc_pkg::OP_STORE, {i[3:0], 60'd0});
      setup_cache(0, 0, 8);
      for (int i = 0; i < 10; i++) send_access(salc_pkg::OP_MODIFY, 64'(i));
      // narrow associativity over lines left by wider use
      setup_cache(0, 0, 2);
      for (int i = 0; i < 4; i++) send_access(salc_pkg::OP_LOAD, 64'(i));
   endtask

   task automatic test_random_geometries;
      int sb, bb, wy;
      for (int p = 0; p < 8; p++) begin
         sb = $urandom_range(0, 7);
         bb = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 8);
         wy = $urandom_range(0, 15);
         setup_cache(sb, bb, wy);
         random_stream(130, $urandom_range(4, 40));
      end
      setup_cache(6, 0, 8);
      random_stream(120, 300);
      setup_cache(1, 4, 1);
      random_stream(80, 6);
   endtask

   task automatic test_backpressure;
      drain();
      hold_len = 400;
      hold_rsp = 1'b1;
      random_stream(30, 8);
      drain();
      random_stream(50, 8);
   endtask

   // result side
   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
         if (hold_len == 0) hold_rsp = 1'b0;
         else hold_len--;
      end else if ($urandom_range(0, 29) == 0) begin
         hold_len = $urandom_range(5, 30);
         hold_rsp = 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      access_result_type e;
      if (!reset && ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result with no access outstanding");
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_first_hit !== e.fh) begin
               $error("first_hit exp %0d got %0d", e.fh, rsp_first_hit); fail_count++;
            end
            if (rsp_first_miss !== e.fm) begin
               $error("first_miss exp %0d got %0d", e.fm, rsp_first_miss); fail_count++;
            end
            if (rsp_evicted !== e.ev) begin
               $error("evicted exp %0d got %0d", e.ev, rsp_evicted); fail_count++;
            end
            if (rsp_second_hit !== e.sh) begin
               $error("second_hit exp %0d got %0d", e.sh, rsp_second_hit); fail_count++;
            end
            if (rsp_hit_total !== e.hits) begin
               $error("hit_total exp %0d got %0d", e.hits, rsp_hit_total); fail_count++;
            end
            if (rsp_miss_total !== e.misses) begin
               $error("miss_total exp %0d got %0d", e.misses, rsp_miss_total);
               fail_count++;
            end
            if (rsp_eviction_total !== e.evicts) begin
               $error("eviction_total exp %0d got %0d", e.evicts, rsp_eviction_total);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WDOG) begin
         $display("tb_set_assoc_lru_cache_sim NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_geometries();
      test_backpressure();
      drain();
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tb_set_assoc_lru_cache_sim OK");
      end else begin
         $display("tb_set_assoc_lru_cache_sim NOT OK");
      end
      $finish;
   end

endmodule
